// File: rtl/core/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

  // display status codes
  localparam logic [2:0] ST_MENU      = 3'd0;
  localparam logic [2:0] ST_SET       = 3'd1;
  localparam logic [2:0] ST_REENTER   = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_ENTER     = 3'd4;
  localparam logic [2:0] ST_GRANTED   = 3'd5;
  localparam logic [2:0] ST_INCORRECT = 3'd6;
  localparam logic [2:0] ST_LOCKOUT   = 3'd7;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_SET   = 8'h31;  // '1'
  localparam logic [7:0] KEY_ENTER = 8'h32;  // '2'

  localparam logic [3:0] ATTEMPTS_RST = 4'd3;

  typedef struct packed {
    logic [2:0] display_status;
    logic [2:0] digits_entered;
    logic [3:0] attempts_left;
    logic       access_granted;
  } kcl_result_t;

endpackage

// File: rtl/core/keypad_code_lock.sv
`timescale 1ns / 1ps
// A key transferred at an edge is on out_* with out_valid from that edge.
// Throughput: one key per cycle while in_stall is low; the lock state and result register update together.
// in_stall follows out_stall only while a result is held in the output register.
// Reset (rst_n low, synchronous): menu phase, stored code zero, count zero,
// attempts and max_attempts 3, no result pending.

module keypad_code_lock import kcl_pkg::*; #(
  parameter int CODE_LEN = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // config
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  // key input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_key_char,
  // status output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_display_status,
  output logic [2:0] out_digits_entered,
  output logic [3:0] out_attempts_left,
  output logic       out_access_granted
);

  logic [3:0]  max_attempts_r;
  logic        in_xfer;
  logic        busy;
  kcl_result_t res;

  // attempt limit; zero is promoted to one where attempts reload
  always_ff @(posedge clk) begin
    if (!rst_n)         max_attempts_r <= ATTEMPTS_RST;
    else if (cfg_wr_en) max_attempts_r <= cfg_wr_data;
  end

  // a key transfers whenever the result slot is free or being drained
  assign in_stall = busy;
  assign in_xfer  = in_valid && !busy;

  // lock state machine: key handling and code compare in one pass
  kcl_fsm #(
    .CODE_LEN (CODE_LEN)
  ) u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_xfer),
    .key          (in_key_char),
    .max_attempts (max_attempts_r),
    .res          (res)
  );

  // result register toward the display side
  kcl_out_reg u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (in_xfer),
    .res                (res),
    .out_stall          (out_stall),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_display_status (out_display_status),
    .out_digits_entered (out_digits_entered),
    .out_attempts_left  (out_attempts_left),
    .out_access_granted (out_access_granted)
  );

endmodule

// File: rtl/core/kcl_fsm.sv
`timescale 1ns / 1ps

module kcl_fsm import kcl_pkg::*; #(
  parameter int CODE_LEN = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  key,
  input  logic [3:0]  max_attempts,
  output kcl_result_t res
);

  localparam int CNT_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LEN - 1);

  typedef enum logic [2:0] {
    PH_MENU    = 3'd0,
    PH_SET     = 3'd1,
    PH_REENTER = 3'd2,
    PH_ENTER   = 3'd4,
    PH_GRANTED = 3'd5
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       att_r, att_nxt;
  logic [7:0]       stored_r [CODE_LEN];
  logic [7:0]       buf_r    [CODE_LEN];

  logic             last_key;
  logic             code_eq;
  logic [3:0]       reload;
  logic [3:0]       att_dec;
  logic             lockout;
  logic [2:0]       status;
  logic             wr_stored;
  logic             wr_buf;
  logic [CNT_W+2:0] cnt_ext;

  assign last_key = (cnt_r == CNT_LAST);
  assign reload   = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
  assign att_dec  = (att_r != 4'd0) ? att_r - 4'd1 : 4'd0;

  // the last key of a code is compared straight from the input
  always_comb begin
    code_eq = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (i == CODE_LEN - 1) begin
        if (stored_r[i] != key) code_eq = 1'b0;
      end else begin
        if (stored_r[i] != buf_r[i]) code_eq = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    att_nxt   = att_r;
    lockout   = 1'b0;
    wr_stored = 1'b0;
    wr_buf    = 1'b0;
    status    = phase_r;
    if (key != KEY_NONE) begin
      case (phase_r)
        PH_MENU: begin
          if (key == KEY_SET) begin
            phase_nxt = PH_SET;
            cnt_nxt   = '0;
            att_nxt   = reload;
          end else if (key == KEY_ENTER) begin
            phase_nxt = PH_ENTER;
            cnt_nxt   = '0;
            att_nxt   = reload;
          end
          status = phase_nxt;
        end
        PH_SET: begin
          wr_stored = 1'b1;
          cnt_nxt   = last_key ? '0 : cnt_r + 1'b1;
          if (last_key) phase_nxt = PH_REENTER;
          status = phase_nxt;
        end
        PH_REENTER: begin
          wr_buf  = 1'b1;
          cnt_nxt = last_key ? '0 : cnt_r + 1'b1;
          status  = ST_REENTER;
          if (last_key) begin
            if (code_eq) begin
              phase_nxt = PH_ENTER;
              status    = ST_ENTER;
            end else begin
              phase_nxt = PH_SET;
              status    = ST_MISMATCH;
            end
          end
        end
        PH_ENTER: begin
          wr_buf  = 1'b1;
          cnt_nxt = last_key ? '0 : cnt_r + 1'b1;
          status  = ST_ENTER;
          if (last_key) begin
            if (code_eq) begin
              phase_nxt = PH_GRANTED;
              status    = ST_GRANTED;
            end else if (att_dec != 4'd0) begin
              att_nxt = att_dec;
              status  = ST_INCORRECT;
            end else begin
              lockout   = 1'b1;
              status    = ST_LOCKOUT;
              phase_nxt = PH_MENU;
              att_nxt   = reload;
            end
          end
        end
        default: status = ST_GRANTED;
      endcase
    end
  end

  assign cnt_ext                = {3'b000, cnt_nxt};
  assign res.display_status     = status;
  assign res.digits_entered     = cnt_ext[2:0];
  assign res.attempts_left      = lockout ? 4'd0 : att_nxt;
  assign res.access_granted     = (phase_nxt == PH_GRANTED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MENU;
      cnt_r   <= '0;
      att_r   <= ATTEMPTS_RST;
      for (int i = 0; i < CODE_LEN; i++) stored_r[i] <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      att_r   <= att_nxt;
      if (wr_stored) stored_r[cnt_r] <= key;
    end
  end

  // shared by confirm and entry: each pass rewrites it from slot 0
  always_ff @(posedge clk) begin
    if (step && wr_buf) buf_r[cnt_r] <= key;
  end

endmodule

// File: rtl/core/kcl_out_reg.sv
`timescale 1ns / 1ps

module kcl_out_reg import kcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  kcl_result_t res,
  input  logic        out_stall,
  output logic        busy,
  output logic        out_valid,
  output logic [2:0]  out_display_status,
  output logic [2:0]  out_digits_entered,
  output logic [3:0]  out_attempts_left,
  output logic        out_access_granted
);

  logic        valid_r, valid_nxt;
  kcl_result_t res_r;

  assign busy      = valid_r && out_stall;
  assign valid_nxt = load || busy;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_valid          = valid_r;
  assign out_display_status = res_r.display_status;
  assign out_digits_entered = res_r.digits_entered;
  assign out_attempts_left  = res_r.attempts_left;
  assign out_access_granted = res_r.access_granted;

endmodule
